/* src/apls_pkg.sv */
// Package of shared types and constants for the angle position loop.
`default_nettype none
package apls_pkg;

   // Field widths.
   localparam int ANGLE_W = 16;
   localparam int DT_W    = 16;
   localparam int COEF_W  = 16;
   localparam int SPEED_W = 24;
   localparam int ERR_W   = 17;
   localparam int WANT_W  = 25;
   localparam int LIMIT_W = 20;
   localparam int DIFF_W  = 22;

   // Register indexes on the control port.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ACCEL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE    = 3'd4;

   // Register values after reset.
   localparam logic [COEF_W-1:0] GAIN_RESET  = 16'd2560;
   localparam logic [COEF_W-1:0] ACCEL_RESET = 16'd5120;

   // Deadband of 0.001 turn and the speed range.
   localparam logic signed [ERR_W-1:0]   DEADBAND_POS = 17'sd65;
   localparam logic signed [ERR_W-1:0]   DEADBAND_NEG = -17'sd65;
   localparam logic signed [SPEED_W-1:0] SPEED_MAX    = 24'sh7FFFFF;
   localparam logic signed [SPEED_W-1:0] SPEED_MIN    = 24'sh800000;

   // Serial multiplier: signed multiplicand times unsigned multiplier.
   localparam int MUL_A_W   = 24;
   localparam int MUL_B_W   = 16;
   localparam int MUL_P_W   = MUL_A_W + 1 + MUL_B_W;
   localparam int MUL_CNT_W = 5;
   localparam logic [MUL_CNT_W-1:0] MUL_STEPS = 5'd16;

   typedef struct packed {
      logic                      start;
      logic signed [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0]        b;
   } mul_req_type;

endpackage
`default_nettype wire

/* src/apls_if.sv */
// Handshake interfaces for the tick, result and control channels.
`default_nettype none
interface apls_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] encoder_angle;
   logic [15:0] time_step;

   modport source (output valid, output encoder_angle, output time_step, input ready);
   modport sink   (input valid, input encoder_angle, input time_step, output ready);
endinterface

interface apls_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] motor_phase;
   logic        reached;
   logic [23:0] velocity;

   modport source (output valid, output motor_phase, output reached, output velocity,
                   input ready);
   modport sink   (input valid, input motor_phase, input reached, input velocity,
                   output ready);
endinterface

interface apls_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* src/apls_mul.sv */
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
`default_nettype none
module apls_mul (
   input  wire                                      clock,
   input  wire                                      reset,
   input  apls_pkg::mul_req_type                    mul_req,
   output logic                                     mul_done,
   output logic signed [apls_pkg::MUL_P_W-1:0]      mul_product
);
   import apls_pkg::*;

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [MUL_CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [MUL_A_W-1:0]   a_ff, a_in;
   logic signed [MUL_A_W:0]     hi_ff, hi_in;
   logic [MUL_B_W-1:0]          lo_ff, lo_in;
   logic signed [MUL_A_W:0]     sum;

   // One step: add the multiplicand if the low bit is set, then shift right.
   always_comb begin
      sum     = hi_ff + (lo_ff[0] ? {a_ff[MUL_A_W-1], a_ff} : '0);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      if (mul_req.start) begin
         busy_in = 1'b1;
         cnt_in  = MUL_STEPS;
         a_in    = mul_req.a;
         hi_in   = '0;
         lo_in   = mul_req.b;
      end else if (busy_ff) begin
         hi_in  = sum >>> 1;
         lo_in  = {sum[0], lo_ff[MUL_B_W-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == MUL_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control flags are reset; the operand and product registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff  <= a_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign mul_done    = done_ff;
   assign mul_product = {hi_ff, lo_ff};

endmodule
`default_nettype wire

/* src/angle_position_loop_slew_limited.sv */
// Top level of the slew-limited angle position loop.
//
//   channel   direction   transfer when            carries
//   req_bus   in          req_bus valid & ready    encoder_angle, time_step
//   rsp_bus   out         rsp_bus valid & ready    motor_phase, reached, velocity
//   csr_bus   in          csr_bus valid & ready    index, data (always ready)
//
// An enabled tick outside the deadband has its result in the output register after
// three products from the shared bit-serial multiplier (start, 16 steps, done),
// then clamp, saturation and output.
// A disabled tick or one inside the deadband goes straight to the output state.
// One tick is in work at a time; the next transfer can be taken once the result
// sits in the output register, which holds it while rsp_bus is stalled.
// Reset is synchronous and restores the register defaults and zero state.
`default_nettype none
module angle_position_loop_slew_limited (
   input wire          clock,
   input wire          reset,
   apls_req_if.sink    req_bus,
   apls_rsp_if.source  rsp_bus,
   apls_csr_if.sink    csr_bus
);
   import apls_pkg::*;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_WANT_GO   = 4'd1;
   localparam logic [3:0] S_WANT_RUN  = 4'd2;
   localparam logic [3:0] S_LIMIT_GO  = 4'd3;
   localparam logic [3:0] S_LIMIT_RUN = 4'd4;
   localparam logic [3:0] S_CLAMP     = 4'd5;
   localparam logic [3:0] S_SPEED     = 4'd6;
   localparam logic [3:0] S_STEP_GO   = 4'd7;
   localparam logic [3:0] S_STEP_RUN  = 4'd8;
   localparam logic [3:0] S_OUT       = 4'd9;

   // Control registers.
   logic [ANGLE_W-1:0] target_ff, offset_ff;
   logic [COEF_W-1:0]  gain_ff, accel_ff;
   logic               enable_ff;

   // Loop state and working registers.
   logic [3:0]                state_ff, state_in;
   logic signed [SPEED_W-1:0] prev_ff, prev_in;
   logic [ANGLE_W-1:0]        phase_ff, phase_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic [DT_W-1:0]           dt_ff, dt_in;
   logic signed [WANT_W-1:0]  want_ff, want_in;
   logic [LIMIT_W-1:0]        limit_ff, limit_in;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic signed [SPEED_W-1:0] speed_ff, speed_in;
   logic                      reached_ff, reached_in;

   // Output register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [ANGLE_W-1:0]        rsp_phase_ff, rsp_phase_in;
   logic                      rsp_reached_ff, rsp_reached_in;
   logic [SPEED_W-1:0]        rsp_velocity_ff, rsp_velocity_in;

   // Multiplier link.
   mul_req_type                 mul_req;
   logic                        mul_done;
   logic signed [MUL_P_W-1:0]   mul_product;

   // Error terms computed at the tick transfer.
   logic [ANGLE_W-1:0]        goal, wrap_d;
   logic signed [ERR_W-1:0]   err_new;
   logic                      in_deadband;
   logic                      req_take, rsp_free;

   // Clamp and saturation terms.
   logic signed [WANT_W:0]    diff_raw;
   logic signed [WANT_W:0]    limit_pos, limit_neg;
   logic signed [SPEED_W+2:0] speed_raw;

   apls_mul u_apls_mul (
      .clock       (clock),
      .reset       (reset),
      .mul_req     (mul_req),
      .mul_done    (mul_done),
      .mul_product (mul_product)
   );

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_take      = req_bus.valid && (state_ff == S_IDLE);
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;

   // Shortest wrapped error; half a turn maps to plus half a turn.
   always_comb begin
      goal        = target_ff + offset_ff;
      wrap_d      = goal - req_bus.encoder_angle;
      err_new     = (!wrap_d[ANGLE_W-1] || wrap_d == 16'h8000) ? {1'b0, wrap_d}
                                                              : {1'b1, wrap_d};
      in_deadband = (err_new >= DEADBAND_NEG) && (err_new <= DEADBAND_POS);
   end

   // Clamp of the speed change and saturation of the new speed.
   always_comb begin
      diff_raw  = (WANT_W+1)'(want_ff) - (WANT_W+1)'(prev_ff);
      limit_pos = (WANT_W+1)'({1'b0, limit_ff});
      limit_neg = -limit_pos;
      speed_raw = (SPEED_W+3)'(prev_ff) + (SPEED_W+3)'(diff_ff);
   end

   // Multiplier operands for each of the three products.
   always_comb begin
      mul_req.start = 1'b0;
      mul_req.a     = (MUL_A_W)'(err_ff);
      mul_req.b     = gain_ff;
      case (state_ff)
         S_WANT_GO: begin
            mul_req.start = 1'b1;
         end
         S_LIMIT_GO: begin
            mul_req.start = 1'b1;
            mul_req.a     = {{(MUL_A_W-COEF_W){1'b0}}, accel_ff};
            mul_req.b     = dt_ff;
         end
         S_STEP_GO: begin
            mul_req.start = 1'b1;
            mul_req.a     = speed_ff;
            mul_req.b     = dt_ff;
         end
         default: begin
            mul_req.start = 1'b0;
         end
      endcase
   end

   // Tick sequencer.
   always_comb begin
      state_in        = state_ff;
      prev_in         = prev_ff;
      phase_in        = phase_ff;
      err_in          = err_ff;
      dt_in           = dt_ff;
      want_in         = want_ff;
      limit_in        = limit_ff;
      diff_in         = diff_ff;
      speed_in        = speed_ff;
      reached_in      = reached_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      rsp_phase_in    = rsp_phase_ff;
      rsp_reached_in  = rsp_reached_ff;
      rsp_velocity_in = rsp_velocity_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               err_in     = err_new;
               dt_in      = req_bus.time_step;
               reached_in = 1'b0;
               if (!enable_ff) begin
                  state_in = S_OUT;
               end else if (in_deadband) begin
                  reached_in = 1'b1;
                  state_in   = S_OUT;
               end else begin
                  state_in = S_WANT_GO;
               end
            end
         end
         S_WANT_GO:  state_in = S_WANT_RUN;
         S_WANT_RUN: begin
            if (mul_done) begin
               want_in  = mul_product[WANT_W+7:8];
               state_in = S_LIMIT_GO;
            end
         end
         S_LIMIT_GO:  state_in = S_LIMIT_RUN;
         S_LIMIT_RUN: begin
            if (mul_done) begin
               limit_in = mul_product[LIMIT_W+11:12];
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            if (diff_raw > limit_pos) begin
               diff_in = DIFF_W'(limit_pos);
            end else if (diff_raw < limit_neg) begin
               diff_in = DIFF_W'(limit_neg);
            end else begin
               diff_in = DIFF_W'(diff_raw);
            end
            state_in = S_SPEED;
         end
         S_SPEED: begin
            if (speed_raw > (SPEED_W+3)'(SPEED_MAX)) begin
               speed_in = SPEED_MAX;
            end else if (speed_raw < (SPEED_W+3)'(SPEED_MIN)) begin
               speed_in = SPEED_MIN;
            end else begin
               speed_in = SPEED_W'(speed_raw);
            end
            state_in = S_STEP_GO;
         end
         S_STEP_GO:  state_in = S_STEP_RUN;
         S_STEP_RUN: begin
            if (mul_done) begin
               phase_in = phase_ff + mul_product[ANGLE_W+19:20];
               prev_in  = speed_ff;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_phase_in    = phase_ff;
               rsp_reached_in  = reached_ff;
               rsp_velocity_in = prev_ff;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         offset_ff <= '0;
         gain_ff   <= GAIN_RESET;
         accel_ff  <= ACCEL_RESET;
         enable_ff <= 1'b0;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_TARGET:    target_ff <= csr_bus.data;
            CSR_OFFSET:    offset_ff <= csr_bus.data;
            CSR_GAIN:      gain_ff   <= csr_bus.data;
            CSR_MAX_ACCEL: accel_ff  <= csr_bus.data;
            CSR_ENABLE:    enable_ff <= csr_bus.data[0];
            default:       ;
         endcase
      end
   end

   // Sequencer, loop state and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prev_ff      <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      err_ff          <= err_in;
      dt_ff           <= dt_in;
      want_ff         <= want_in;
      limit_ff        <= limit_in;
      diff_ff         <= diff_in;
      speed_ff        <= speed_in;
      reached_ff      <= reached_in;
      rsp_phase_ff    <= rsp_phase_in;
      rsp_reached_ff  <= rsp_reached_in;
      rsp_velocity_ff <= rsp_velocity_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.motor_phase = rsp_phase_ff;
   assign rsp_bus.reached     = rsp_reached_ff;
   assign rsp_bus.velocity    = rsp_velocity_ff;

endmodule
`default_nettype wire

/* src/apls_checker.sv */
// Port-level checks for the angle position loop, bound to the top level.
`default_nettype none
module apls_checker (
   input wire clock,
   input wire reset,
   input wire req_valid,
   input wire req_ready,
   input wire rsp_valid,
   input wire rsp_ready,
   input wire csr_ready
);

   // A result offered but not taken stays offered.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result withdrawn before its transfer");

   // Reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // Only one tick is in work: the input closes after each transfer.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("tick taken while another is in work");

   // The control port never stalls.
   assert property (@(posedge clock) csr_ready)
      else $error("control port stalled");

endmodule

bind angle_position_loop_slew_limited apls_checker u_apls_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .csr_ready (csr_bus.ready)
);
`default_nettype wire
